// ===== hw/rtl/script_byte_tokenizer_macros.svh =====
// assertion helpers for the tokenizer
`ifndef SCRIPT_BYTE_TOKENIZER_MACROS_SVH
`define SCRIPT_BYTE_TOKENIZER_MACROS_SVH

`define SBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sbt_pkg.sv =====
`timescale 1ns / 1ps

package sbt_pkg;

    localparam int MAX_WORD_LEN = 10;
    localparam int LINE_BITS    = 24;
    localparam int COLUMN_BITS  = 16;
    localparam int LEN_BITS     = 16;
    localparam int NUM_WORDS    = 29;
    localparam int TAB_LEN      = 10;

    typedef enum logic [3:0] {
        M_IDLE, M_DONE, M_OP, M_WORD, M_INT, M_DOT, M_FRAC, M_EXPS, M_EXPD,
        M_STR, M_LCOM, M_BCOM
    } t_mode;

    localparam logic [6:0] K_EOF   = 7'd0;
    localparam logic [6:0] K_ERR   = 7'd1;
    localparam logic [6:0] K_NUM   = 7'd2;
    localparam logic [6:0] K_STR   = 7'd3;
    localparam logic [6:0] K_ID    = 7'd4;
    localparam logic [6:0] K_PLUS  = 7'd33;
    localparam logic [6:0] K_MINUS = 7'd36;
    localparam logic [6:0] K_MUL   = 7'd39;
    localparam logic [6:0] K_DIV   = 7'd41;
    localparam logic [6:0] K_MOD   = 7'd43;
    localparam logic [6:0] K_ASSIGN = 7'd45;
    localparam logic [6:0] K_EQ    = 7'd46;
    localparam logic [6:0] K_NOT   = 7'd49;
    localparam logic [6:0] K_NE    = 7'd50;
    localparam logic [6:0] K_LT    = 7'd52;
    localparam logic [6:0] K_SHL   = 7'd54;
    localparam logic [6:0] K_GT    = 7'd56;
    localparam logic [6:0] K_SHR   = 7'd58;
    localparam logic [6:0] K_USHR  = 7'd60;
    localparam logic [6:0] K_AND   = 7'd62;
    localparam logic [6:0] K_OR    = 7'd65;
    localparam logic [6:0] K_XOR   = 7'd68;
    localparam logic [6:0] K_DOT   = 7'd73;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_CHAR  = 2'd1;
    localparam logic [1:0] E_UNTERM = 2'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef logic [TAB_LEN*8-1:0] t_wtext;

    function automatic t_wtext word_text(input int i);
        case (i)
            0: word_text = {"function", 16'h0};
            1: word_text = {"var", 56'h0};
            2: word_text = {"let", 56'h0};
            3: word_text = {"const", 40'h0};
            4: word_text = {"if", 64'h0};
            5: word_text = {"else", 48'h0};
            6: word_text = {"while", 40'h0};
            7: word_text = {"for", 56'h0};
            8: word_text = {"return", 32'h0};
            9: word_text = {"break", 40'h0};
            10: word_text = {"continue", 16'h0};
            11: word_text = {"new", 56'h0};
            12: word_text = {"this", 48'h0};
            13: word_text = {"typeof", 32'h0};
            14: word_text = "instanceof";
            15: word_text = {"in", 64'h0};
            16: word_text = {"delete", 32'h0};
            17: word_text = {"void", 48'h0};
            18: word_text = {"switch", 32'h0};
            19: word_text = {"case", 48'h0};
            20: word_text = {"default", 24'h0};
            21: word_text = {"try", 56'h0};
            22: word_text = {"catch", 40'h0};
            23: word_text = {"finally", 24'h0};
            24: word_text = {"throw", 40'h0};
            25: word_text = {"true", 48'h0};
            26: word_text = {"false", 40'h0};
            27: word_text = {"null", 48'h0};
            default: word_text = {"undefined", 8'h0};
        endcase
    endfunction

    function automatic logic [3:0] word_len(input int i);
        case (i)
            0, 10: word_len = 4'd8;
            1, 2, 7, 11, 21: word_len = 4'd3;
            3, 6, 9, 22, 24, 26: word_len = 4'd5;
            4, 15: word_len = 4'd2;
            5, 12, 17, 19, 25, 27: word_len = 4'd4;
            8, 13, 16, 18: word_len = 4'd6;
            14: word_len = 4'd10;
            20, 23: word_len = 4'd7;
            default: word_len = 4'd9;
        endcase
    endfunction

    function automatic logic [6:0] word_kind(input int i);
        if (i < 25) word_kind = 7'(i + 5);
        else if (i < 27) word_kind = 7'd30;
        else word_kind = 7'(i + 4);
    endfunction

    function automatic logic [6:0] op_start(input logic [7:0] c);
        case (c)
            "+": op_start = K_PLUS;
            "-": op_start = K_MINUS;
            "*": op_start = K_MUL;
            "/": op_start = K_DIV;
            "%": op_start = K_MOD;
            "=": op_start = K_ASSIGN;
            "!": op_start = K_NOT;
            "<": op_start = K_LT;
            ">": op_start = K_GT;
            "&": op_start = K_AND;
            "|": op_start = K_OR;
            "^": op_start = K_XOR;
            "~": op_start = 7'd70;
            ";": op_start = 7'd71;
            ",": op_start = 7'd72;
            ".": op_start = K_DOT;
            ":": op_start = 7'd74;
            "?": op_start = 7'd75;
            "(": op_start = 7'd76;
            ")": op_start = 7'd77;
            "{": op_start = 7'd78;
            "}": op_start = 7'd79;
            "[": op_start = 7'd80;
            "]": op_start = 7'd81;
            default: op_start = K_EOF;
        endcase
    endfunction

    function automatic logic [6:0] op_extend(input logic [6:0] k, input logic [7:0] c);
        op_extend = K_EOF;
        case (k)
            K_PLUS: op_extend = (c == "+") ? 7'd34 : (c == "=") ? 7'd35 : K_EOF;
            K_MINUS: op_extend = (c == "-") ? 7'd37 : (c == "=") ? 7'd38 : K_EOF;
            K_MUL: op_extend = (c == "=") ? 7'd40 : K_EOF;
            K_DIV: op_extend = (c == "=") ? 7'd42 : K_EOF;
            K_MOD: op_extend = (c == "=") ? 7'd44 : K_EOF;
            K_ASSIGN: op_extend = (c == "=") ? K_EQ : (c == ">") ? 7'd48 : K_EOF;
            K_EQ: op_extend = (c == "=") ? 7'd47 : K_EOF;
            K_NOT: op_extend = (c == "=") ? K_NE : K_EOF;
            K_NE: op_extend = (c == "=") ? 7'd51 : K_EOF;
            K_LT: op_extend = (c == "=") ? 7'd53 : (c == "<") ? K_SHL : K_EOF;
            K_SHL: op_extend = (c == "=") ? 7'd55 : K_EOF;
            K_GT: op_extend = (c == "=") ? 7'd57 : (c == ">") ? K_SHR : K_EOF;
            K_SHR: op_extend = (c == ">") ? K_USHR : (c == "=") ? 7'd59 : K_EOF;
            K_USHR: op_extend = (c == "=") ? 7'd61 : K_EOF;
            K_AND: op_extend = (c == "&") ? 7'd63 : (c == "=") ? 7'd64 : K_EOF;
            K_OR: op_extend = (c == "|") ? 7'd66 : (c == "=") ? 7'd67 : K_EOF;
            K_XOR: op_extend = (c == "=") ? 7'd69 : K_EOF;
            default: op_extend = K_EOF;
        endcase
    endfunction

    function automatic logic op_open(input logic [6:0] k);
        op_open = (k == K_PLUS) || (k == K_MINUS) || (k == K_MUL) || (k == K_DIV)
            || (k == K_MOD) || (k == K_ASSIGN) || (k == K_EQ) || (k == K_NOT)
            || (k == K_NE) || (k == K_LT) || (k == K_SHL) || (k == K_GT)
            || (k == K_SHR) || (k == K_USHR) || (k == K_AND) || (k == K_OR)
            || (k == K_XOR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction

endpackage

// ===== hw/rtl/script_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// results of a transaction are written into the result queue when it is accepted
// throughput: one byte per cycle while o_ready is high; a byte can yield a second result
// the two-entry result queue sets the rate; input is taken when the queue is empty, or holds one entry being taken
// reset: synchronous active low, clears scan state, line and column to 1, empties the queue

module script_byte_tokenizer #(
    parameter int MAX_WORD_LEN = sbt_pkg::MAX_WORD_LEN,
    parameter int LINE_BITS    = sbt_pkg::LINE_BITS,
    parameter int COLUMN_BITS  = sbt_pkg::COLUMN_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_token_kind,
    output logic [1:0]  o_error_code,
    output logic        o_bool_value,
    output logic [23:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [15:0] o_token_length,
    output logic        o_last
);

`include "script_byte_tokenizer_macros.svh"

    localparam int LB = LINE_BITS;
    localparam int CB = COLUMN_BITS;
    localparam int WB = $clog2(MAX_WORD_LEN + 2);
    localparam int WI = $clog2(MAX_WORD_LEN);
    localparam logic [LB-1:0] LN_TOP = {LB{1'b1}};
    localparam logic [CB-1:0] COL_TOP = {CB{1'b1}};
    localparam logic [15:0] LEN_TOP = 16'hFFFF;

    typedef struct packed {
        logic [6:0]  kind;
        logic [1:0]  err;
        logic        bv;
        logic [23:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } t_tok;

    sbt_pkg::t_mode r_mode, n_mode;
    logic [6:0]    r_prefix, n_prefix;
    logic [7:0]    r_wbuf [MAX_WORD_LEN];
    logic [WB-1:0] r_wcnt, n_wcnt;
    logic          r_quote, n_quote;
    logic          r_esc, n_esc;
    logic          r_star, n_star;
    logic [LB-1:0] r_cline, n_cline;
    logic [CB-1:0] r_ccol, n_ccol;
    logic [LB-1:0] r_tline, n_tline;
    logic [CB-1:0] r_tcol, n_tcol;
    logic [15:0]   r_len, n_len;
    logic          r_errh, n_errh;
    logic [6:0]    r_hkind, n_hkind;
    logic [1:0]    r_herr, n_herr;
    logic [CB-1:0] r_dcol, n_dcol;

    t_tok          r_q [2];
    logic [1:0]    r_qcnt;
    t_tok          t0, t1;
    logic [1:0]    nres;
    logic          wpush;

    logic          acc;
    logic [7:0]    c;
    logic [6:0]    wkind;
    logic          wbv;

    assign acc = i_valid && o_ready;
    assign c = i_source_byte;
    assign o_ready = (r_qcnt == 2'd0) || (r_qcnt == 2'd1 && i_ready);

    function automatic logic [23:0] sat_line(input logic [LB-1:0] v);
        if (LB > 24 && v > LB'(24'hFFFFFF)) sat_line = 24'hFFFFFF;
        else sat_line = 24'(v);
    endfunction

    function automatic logic [15:0] sat_col(input logic [CB-1:0] v);
        if (CB > 16 && v > CB'(16'hFFFF)) sat_col = 16'hFFFF;
        else sat_col = 16'(v);
    endfunction

    always_comb begin
        logic [TAB_LEN_W-1:0] dummy;
        dummy = '0;
    end
    localparam int TAB_LEN_W = 1;

    always_comb begin
        logic [sbt_pkg::TAB_LEN*8-1:0] buf_text;
        buf_text = '0;
        for (int j = 0; j < sbt_pkg::TAB_LEN; j++) begin
            if (j < MAX_WORD_LEN && WB'(j) < r_wcnt)
                buf_text[(sbt_pkg::TAB_LEN-1-j)*8 +: 8] = r_wbuf[j < MAX_WORD_LEN ? j : 0];
        end
        wkind = sbt_pkg::K_ID;
        wbv = 1'b0;
        for (int i = 0; i < sbt_pkg::NUM_WORDS; i++) begin
            if (r_wcnt == WB'(sbt_pkg::word_len(i)) && buf_text == sbt_pkg::word_text(i)) begin
                wkind = sbt_pkg::word_kind(i);
                wbv = (i == 25);
            end
        end
    end

    always_comb begin
        logic [6:0] k;
        logic       done;
        logic [CB-1:0] col_i;
        logic [15:0]   len_i;
        n_mode = r_mode; n_prefix = r_prefix; n_wcnt = r_wcnt; n_quote = r_quote;
        n_esc = r_esc; n_star = r_star; n_cline = r_cline; n_ccol = r_ccol;
        n_tline = r_tline; n_tcol = r_tcol; n_len = r_len; n_errh = r_errh;
        n_hkind = r_hkind; n_herr = r_herr; n_dcol = r_dcol;
        wpush = 1'b0;
        nres = 2'd0;
        t0 = '0; t1 = '0;
        done = 1'b1;
        k = '0;
        col_i = (r_ccol < COL_TOP) ? r_ccol + 1'b1 : r_ccol;
        len_i = (r_len < LEN_TOP) ? r_len + 1'b1 : r_len;

        if (i_command == sbt_pkg::CMD_END) begin
            case (r_mode)
                sbt_pkg::M_DONE: begin
                    t0 = '{r_hkind, r_herr, 1'b0, sat_line(r_tline), sat_col(r_tcol), r_len, 1'b0};
                    nres = 2'd1;
                end
                sbt_pkg::M_OP: begin
                    t0 = '{r_prefix, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline), sat_col(r_tcol),
                           r_len, 1'b0};
                    nres = 2'd1;
                end
                sbt_pkg::M_WORD: begin
                    t0 = '{wkind, sbt_pkg::E_NONE, wbv, sat_line(r_tline), sat_col(r_tcol),
                           r_len, 1'b0};
                    nres = 2'd1;
                end
                sbt_pkg::M_INT, sbt_pkg::M_DOT, sbt_pkg::M_FRAC, sbt_pkg::M_EXPS,
                sbt_pkg::M_EXPD: begin
                    t0 = '{sbt_pkg::K_NUM, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                           sat_col(r_tcol), r_len, 1'b0};
                    nres = 2'd1;
                end
                sbt_pkg::M_STR: begin
                    t0 = '{sbt_pkg::K_ERR, sbt_pkg::E_UNTERM, 1'b0, sat_line(r_cline),
                           sat_col(r_ccol), r_len, 1'b0};
                    nres = 2'd1;
                end
                default: nres = 2'd0;
            endcase
            if (nres == 2'd1)
                t1 = '{sbt_pkg::K_EOF, sbt_pkg::E_NONE, 1'b0, sat_line(r_cline),
                       sat_col(r_ccol), 16'd0, 1'b1};
            else
                t0 = '{sbt_pkg::K_EOF, sbt_pkg::E_NONE, 1'b0, sat_line(r_cline),
                       sat_col(r_ccol), 16'd0, 1'b1};
            nres = nres + 2'd1;
            n_mode = sbt_pkg::M_IDLE; n_prefix = '0; n_wcnt = '0; n_quote = 1'b0;
            n_esc = 1'b0; n_star = 1'b0; n_cline = LB'(1); n_ccol = CB'(1);
            n_tline = LB'(1); n_tcol = CB'(1); n_len = '0; n_errh = 1'b0;
            n_hkind = '0; n_herr = '0; n_dcol = '0;
        end else begin
            done = 1'b1;
            case (r_mode)
                sbt_pkg::M_DONE: begin
                    t0 = '{r_hkind, r_herr, 1'b0, sat_line(r_tline), sat_col(r_tcol), r_len, 1'b0};
                    nres = 2'd1;
                    n_mode = sbt_pkg::M_IDLE;
                    done = r_errh;
                    if (!r_errh) done = 1'b0;
                end
                sbt_pkg::M_OP: begin
                    k = sbt_pkg::op_extend(r_prefix, c);
                    if (r_prefix == sbt_pkg::K_DIV && c == "/") begin
                        n_ccol = col_i; n_mode = sbt_pkg::M_LCOM;
                    end else if (r_prefix == sbt_pkg::K_DIV && c == "*") begin
                        n_ccol = col_i; n_star = 1'b0; n_mode = sbt_pkg::M_BCOM;
                    end else if (k != sbt_pkg::K_EOF) begin
                        n_ccol = col_i; n_len = len_i;
                        if (sbt_pkg::op_open(k)) n_prefix = k;
                        else begin
                            n_prefix = '0; n_hkind = k; n_herr = sbt_pkg::E_NONE;
                            n_mode = sbt_pkg::M_DONE;
                        end
                    end else begin
                        t0 = '{r_prefix, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                               sat_col(r_tcol), r_len, 1'b0};
                        nres = 2'd1;
                        n_prefix = '0;
                        done = 1'b0;
                    end
                end
                sbt_pkg::M_WORD: begin
                    if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c)) begin
                        wpush = (r_wcnt < WB'(MAX_WORD_LEN));
                        n_wcnt = wpush ? r_wcnt + 1'b1 : WB'(MAX_WORD_LEN + 1);
                        n_ccol = col_i; n_len = len_i;
                    end else begin
                        t0 = '{wkind, sbt_pkg::E_NONE, wbv, sat_line(r_tline), sat_col(r_tcol),
                               r_len, 1'b0};
                        nres = 2'd1;
                        done = 1'b0;
                    end
                end
                sbt_pkg::M_INT, sbt_pkg::M_FRAC: begin
                    if (sbt_pkg::is_digit(c)) begin
                        n_ccol = col_i; n_len = len_i;
                    end else if (c == "." && r_mode == sbt_pkg::M_INT) begin
                        n_dcol = r_ccol; n_ccol = col_i; n_len = len_i;
                        n_mode = sbt_pkg::M_DOT;
                    end else if (c == "e" || c == "E") begin
                        n_ccol = col_i; n_len = len_i; n_mode = sbt_pkg::M_EXPS;
                    end else begin
                        t0 = '{sbt_pkg::K_NUM, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                               sat_col(r_tcol), r_len, 1'b0};
                        nres = 2'd1;
                        done = 1'b0;
                    end
                end
                sbt_pkg::M_DOT: begin
                    if (sbt_pkg::is_digit(c)) begin
                        n_ccol = col_i; n_len = len_i; n_mode = sbt_pkg::M_FRAC;
                    end else begin
                        t0 = '{sbt_pkg::K_NUM, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                               sat_col(r_tcol), (r_len == LEN_TOP) ? LEN_TOP : r_len - 1'b1,
                               1'b0};
                        t1 = '{sbt_pkg::K_DOT, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                               sat_col(r_dcol), 16'd1, 1'b0};
                        nres = 2'd2;
                        done = 1'b0;
                    end
                end
                sbt_pkg::M_EXPS: begin
                    if (c == "+" || c == "-" || sbt_pkg::is_digit(c)) begin
                        n_ccol = col_i; n_len = len_i; n_mode = sbt_pkg::M_EXPD;
                    end else begin
                        t0 = '{sbt_pkg::K_NUM, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                               sat_col(r_tcol), r_len, 1'b0};
                        nres = 2'd1;
                        done = 1'b0;
                    end
                end
                sbt_pkg::M_EXPD: begin
                    if (sbt_pkg::is_digit(c)) begin
                        n_ccol = col_i; n_len = len_i;
                    end else begin
                        t0 = '{sbt_pkg::K_NUM, sbt_pkg::E_NONE, 1'b0, sat_line(r_tline),
                               sat_col(r_tcol), r_len, 1'b0};
                        nres = 2'd1;
                        done = 1'b0;
                    end
                end
                sbt_pkg::M_STR: begin
                    n_ccol = col_i; n_len = len_i;
                    if (r_esc) n_esc = 1'b0;
                    else if (c == "\\") n_esc = 1'b1;
                    else if (c == (r_quote ? 8'h27 : 8'h22)) begin
                        n_hkind = sbt_pkg::K_STR; n_herr = sbt_pkg::E_NONE;
                        n_mode = sbt_pkg::M_DONE;
                    end
                end
                sbt_pkg::M_LCOM: begin
                    if (c == 8'h0A) begin
                        n_cline = (r_cline < LN_TOP) ? r_cline + 1'b1 : r_cline;
                        n_ccol = CB'(1); n_mode = sbt_pkg::M_IDLE;
                    end else n_ccol = col_i;
                end
                sbt_pkg::M_BCOM: begin
                    if (r_star && c == "/") begin
                        n_ccol = col_i; n_star = 1'b0; n_mode = sbt_pkg::M_IDLE;
                    end else if (c == 8'h0A) begin
                        n_cline = (r_cline < LN_TOP) ? r_cline + 1'b1 : r_cline;
                        n_ccol = CB'(1); n_star = 1'b0;
                    end else begin
                        n_star = (c == "*"); n_ccol = col_i;
                    end
                end
                default: done = r_errh;
            endcase

            // begin a new token with this byte, or skip it if it is whitespace
            if (!done) begin
                n_mode = sbt_pkg::M_IDLE;
                n_prefix = (r_mode == sbt_pkg::M_OP) ? 7'd0 : n_prefix;
                k = sbt_pkg::op_start(c);
                if (c == " " || c == 8'h09 || c == 8'h0D) begin
                    n_ccol = col_i;
                end else if (c == 8'h0A) begin
                    n_cline = (r_cline < LN_TOP) ? r_cline + 1'b1 : r_cline;
                    n_ccol = CB'(1);
                end else begin
                    n_tline = r_cline; n_tcol = r_ccol; n_len = 16'd1; n_ccol = col_i;
                    if (sbt_pkg::is_alpha(c)) begin
                        n_mode = sbt_pkg::M_WORD; n_wcnt = WB'(1); wpush = 1'b1;
                    end else if (sbt_pkg::is_digit(c)) begin
                        n_mode = sbt_pkg::M_INT;
                    end else if (c == 8'h22 || c == 8'h27) begin
                        n_quote = (c == 8'h27); n_esc = 1'b0; n_mode = sbt_pkg::M_STR;
                    end else if (k != sbt_pkg::K_EOF) begin
                        if (sbt_pkg::op_open(k)) begin
                            n_prefix = k; n_mode = sbt_pkg::M_OP;
                        end else begin
                            n_hkind = k; n_herr = sbt_pkg::E_NONE; n_mode = sbt_pkg::M_DONE;
                        end
                    end else begin
                        n_tcol = col_i; n_errh = 1'b1;
                        n_hkind = sbt_pkg::K_ERR; n_herr = sbt_pkg::E_CHAR;
                        n_mode = sbt_pkg::M_DONE;
                    end
                end
            end
            if (nres == 2'd1) t0.last = 1'b1;
            if (nres == 2'd2) t1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sbt_pkg::M_IDLE;
            r_prefix <= '0; r_wcnt <= '0; r_quote <= 1'b0; r_esc <= 1'b0;
            r_star <= 1'b0; r_cline <= LB'(1); r_ccol <= CB'(1);
            r_tline <= LB'(1); r_tcol <= CB'(1); r_len <= '0; r_errh <= 1'b0;
            r_hkind <= '0; r_herr <= '0; r_dcol <= '0;
        end else if (acc) begin
            r_mode <= n_mode; r_prefix <= n_prefix; r_wcnt <= n_wcnt;
            r_quote <= n_quote; r_esc <= n_esc; r_star <= n_star;
            r_cline <= n_cline; r_ccol <= n_ccol; r_tline <= n_tline;
            r_tcol <= n_tcol; r_len <= n_len; r_errh <= n_errh;
            r_hkind <= n_hkind; r_herr <= n_herr; r_dcol <= n_dcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_command == sbt_pkg::CMD_BYTE && wpush)
            r_wbuf[(n_mode == sbt_pkg::M_WORD && n_wcnt == WB'(1)) ? WI'(0)
                   : r_wcnt[WI-1:0]] <= c;
    end

    // two-entry result queue, head at index 0
    always_ff @(posedge i_clk) begin
        logic [1:0] cnt;
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            cnt = r_qcnt;
            if (o_valid && i_ready) begin
                r_q[0] <= r_q[1];
                cnt = cnt - 1'b1;
            end
            if (acc) begin
                if (nres != 2'd0) begin
                    if (cnt == 2'd0) r_q[0] <= t0; else r_q[1] <= t0;
                end
                if (nres == 2'd2) r_q[1] <= t1;
                cnt = cnt + nres;
            end
            r_qcnt <= cnt;
        end
    end

    assign o_valid = (r_qcnt != 2'd0);
    assign o_token_kind = r_q[0].kind;
    assign o_error_code = r_q[0].err;
    assign o_bool_value = r_q[0].bv;
    assign o_start_line = r_q[0].line;
    assign o_start_column = r_q[0].col;
    assign o_token_length = r_q[0].len;
    assign o_last = r_q[0].last;

    `SBT_ASSERT_IMPL(a_qcnt_range, i_clk, i_rst_n, 1'b1, r_qcnt != 2'd3,
        "result queue overflow")
    `SBT_ASSERT_IMPL(a_ready_room, i_clk, i_rst_n, o_ready, r_qcnt != 2'd2,
        "ready with full queue")
    `SBT_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, acc && i_command == sbt_pkg::CMD_END,
        r_mode == sbt_pkg::M_IDLE && r_errh == 1'b0, "end of source did not restart")
    `SBT_ASSERT_NEXT(a_end_emits, i_clk, i_rst_n, acc && i_command == sbt_pkg::CMD_END,
        o_valid, "end of source produced no result")

endmodule
